/* hdl/irr_pkg.sv */
package irr_pkg;

    localparam int STORE_DEPTH = 128;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int HEAD_LEN    = 4;
    localparam logic [15:0] PLEN_MAX = 16'(STORE_DEPTH - HEAD_LEN);

    localparam logic [7:0] IDLE_LIMIT_RESET = 8'd8;

    localparam logic [7:0] CH_O = 8'h4F;
    localparam logic [7:0] CH_K = 8'h4B;
    localparam logic [7:0] CH_F = 8'h46;
    localparam logic [7:0] CH_L = 8'h4C;
    localparam logic [7:0] CH_P = 8'h50;
    localparam logic [7:0] CH_D = 8'h44;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_BYTE  = 2'd1,
        OP_TICK  = 2'd2,
        OP_READ  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FAIL    = 2'd1,
        ST_TIMEOUT = 2'd2,
        ST_READ    = 2'd3
    } t_status;

    typedef struct packed {
        t_status    status;
        logic [7:0] count;
        logic       is_read;
        logic       entry_valid;
    } t_result;

endpackage

/* hdl/irr_ram.sv */
module irr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hdl/isp_reply_receiver.sv */
// Bootloader reply receiver. One request is accepted every clock cycle unless the
// result path is full and the output side stalls; each result is registered in the
// first stage (alongside the reply-store registered read) and then in the output
// register, and results keep flowing while the output side stalls as long as the
// two-entry result path has room. The reply bytes live in a single-port-write,
// registered-read RAM; a per-entry valid bit cleared by a start request makes
// never-written entries read as zero, so no clearing pass is needed. The first
// four reply bytes are shadowed in registers so the PD / OK / FL header and
// payload length are decoded in the same cycle as the byte that completes them.
module isp_reply_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,    // idle_limit
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // rx_byte[7:0], timeout_limit[23:8], read_index[30:24], zero[31]
    input  logic [31:0] i_s_axis_tdata,
    input  logic [1:0]  i_s_axis_tuser,   // opcode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // received_count[7:0], data_byte[15:8]
    output logic [1:0]  o_m_axis_tuser    // status
);

    localparam int AW = irr_pkg::ADDR_W;
    localparam int CW = irr_pkg::CNT_W;
    localparam int DEPTH = irr_pkg::STORE_DEPTH;

    // request fields
    irr_pkg::t_opcode w_op;
    logic [7:0]       w_rx;
    logic [15:0]      w_tlim;
    logic [6:0]       w_ridx;
    logic [AW-1:0]    w_rd_addr;
    logic             w_ridx_in_range;
    logic             w_accept;

    assign w_op   = irr_pkg::t_opcode'(i_s_axis_tuser);
    assign w_rx   = i_s_axis_tdata[7:0];
    assign w_tlim = i_s_axis_tdata[23:8];
    assign w_ridx = i_s_axis_tdata[30:24];
    assign w_rd_addr = AW'(w_ridx);
    assign w_ridx_in_range = ({25'd0, w_ridx} < 32'(DEPTH));
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;

    // state
    logic [7:0]       r_idle_limit;
    logic             r_listen, n_listen;
    logic [CW-1:0]    r_count, n_count;
    logic [15:0]      r_elapsed, n_elapsed;
    logic [7:0]       r_silent, n_silent;
    logic [15:0]      r_timeout, n_timeout;
    logic [DEPTH-1:0] r_valid, n_valid;
    logic [7:0]       r_head [irr_pkg::HEAD_LEN];
    logic [7:0]       n_head [irr_pkg::HEAD_LEN];

    // working values
    logic [CW-1:0]    w_cnt1;
    logic [15:0]      w_plen_raw;
    logic [15:0]      w_plen;
    logic [16:0]      w_need;
    logic [15:0]      w_e1;
    logic [7:0]       w_s1;
    logic             w_new_ok, w_new_fl, w_old_ok, w_old_fl;
    logic             w_wr_en;
    logic             w_rd_en;

    logic             w_res_valid;
    irr_pkg::t_result w_res;

    // result path
    logic             r_p_valid;
    irr_pkg::t_result r_p_res;
    logic             r_o_valid;
    logic [1:0]       r_o_status;
    logic [7:0]       r_o_count;
    logic [7:0]       r_o_data;
    logic             w_p_adv;
    logic [7:0]       w_rd_data;
    logic [7:0]       w_p_data;

    assign w_p_adv = !r_o_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_p_valid || w_p_adv;

    // header decode on the shadow registers after this byte lands
    assign w_plen_raw = {n_head[3], n_head[2]};
    assign w_plen = (w_plen_raw > irr_pkg::PLEN_MAX) ? irr_pkg::PLEN_MAX : w_plen_raw;
    assign w_need = 17'(irr_pkg::HEAD_LEN) + {1'b0, w_plen};
    assign w_new_ok = (n_head[0] == irr_pkg::CH_O) && (n_head[1] == irr_pkg::CH_K);
    assign w_new_fl = (n_head[0] == irr_pkg::CH_F) && (n_head[1] == irr_pkg::CH_L);
    assign w_old_ok = (r_head[0] == irr_pkg::CH_O) && (r_head[1] == irr_pkg::CH_K)
                   && (r_count >= CW'(2));
    assign w_old_fl = (r_head[0] == irr_pkg::CH_F) && (r_head[1] == irr_pkg::CH_L)
                   && (r_count >= CW'(2));
    assign w_e1 = (r_elapsed == 16'hFFFF) ? r_elapsed : r_elapsed + 16'd1;
    assign w_s1 = (r_silent == 8'hFF) ? r_silent : r_silent + 8'd1;
    assign w_rd_en = w_accept && (w_op == irr_pkg::OP_READ);

    always_comb begin
        n_listen  = r_listen;
        n_count   = r_count;
        n_elapsed = r_elapsed;
        n_silent  = r_silent;
        n_timeout = r_timeout;
        n_valid   = r_valid;
        n_head    = r_head;
        w_cnt1    = r_count;
        w_wr_en   = 1'b0;
        w_res_valid         = 1'b0;
        w_res.status        = irr_pkg::ST_TIMEOUT;
        w_res.count         = 8'(r_count);
        w_res.is_read       = 1'b0;
        w_res.entry_valid   = 1'b0;
        if (w_accept) begin
            unique case (w_op)
                irr_pkg::OP_START: begin
                    n_valid   = '0;
                    for (int i = 0; i < irr_pkg::HEAD_LEN; i++) begin
                        n_head[i] = 8'd0;
                    end
                    n_count   = '0;
                    n_elapsed = 16'd0;
                    n_silent  = 8'd0;
                    n_timeout = w_tlim;
                    if (w_tlim == 16'd0) begin
                        n_listen     = 1'b0;
                        w_res_valid  = 1'b1;
                        w_res.status = irr_pkg::ST_TIMEOUT;
                        w_res.count  = 8'd0;
                    end else begin
                        n_listen = 1'b1;
                    end
                end
                irr_pkg::OP_READ: begin
                    w_res_valid       = 1'b1;
                    w_res.status      = irr_pkg::ST_READ;
                    w_res.is_read     = 1'b1;
                    w_res.entry_valid = w_ridx_in_range && r_valid[w_rd_addr];
                end
                irr_pkg::OP_BYTE: begin
                    if (r_listen) begin
                        n_silent = 8'd0;
                        if (r_count < CW'(DEPTH)) begin
                            w_wr_en = 1'b1;
                            n_valid[r_count[AW-1:0]] = 1'b1;
                            if (r_count < CW'(irr_pkg::HEAD_LEN)) begin
                                n_head[r_count[1:0]] = w_rx;
                            end
                            w_cnt1 = r_count + CW'(1);
                        end
                        if ((w_cnt1 >= CW'(2)) && (n_head[0] == irr_pkg::CH_P)
                                && (n_head[1] == irr_pkg::CH_D)) begin
                            // pending: drop the count and restart the timeout
                            n_count   = '0;
                            n_elapsed = 16'd0;
                        end else begin
                            n_count = w_cnt1;
                            if ((w_new_ok || w_new_fl) && (w_cnt1 >= CW'(irr_pkg::HEAD_LEN))
                                    && (17'(w_cnt1) >= w_need)) begin
                                n_listen     = 1'b0;
                                w_res_valid  = 1'b1;
                                w_res.status = w_new_ok ? irr_pkg::ST_OK : irr_pkg::ST_FAIL;
                                w_res.count  = 8'(w_cnt1);
                            end
                        end
                    end
                end
                irr_pkg::OP_TICK: begin
                    if (r_listen) begin
                        n_elapsed = w_e1;
                        n_silent  = w_s1;
                        priority if ((w_old_ok || w_old_fl) && (w_s1 >= r_idle_limit)) begin
                            n_listen     = 1'b0;
                            w_res_valid  = 1'b1;
                            w_res.status = w_old_ok ? irr_pkg::ST_OK : irr_pkg::ST_FAIL;
                        end else if (w_e1 >= r_timeout) begin
                            n_listen     = 1'b0;
                            w_res_valid  = 1'b1;
                            w_res.status = irr_pkg::ST_TIMEOUT;
                        end else begin
                            n_listen = r_listen;
                        end
                    end
                end
                default: begin
                    n_listen = r_listen;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_limit <= irr_pkg::IDLE_LIMIT_RESET;
            r_listen     <= 1'b0;
            r_count      <= '0;
            r_elapsed    <= 16'd0;
            r_silent     <= 8'd0;
            r_timeout    <= 16'd0;
            r_valid      <= '0;
            for (int i = 0; i < irr_pkg::HEAD_LEN; i++) begin
                r_head[i] <= 8'd0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_idle_limit <= i_cfg_wr_data;
            end
            r_listen  <= n_listen;
            r_count   <= n_count;
            r_elapsed <= n_elapsed;
            r_silent  <= n_silent;
            r_timeout <= n_timeout;
            r_valid   <= n_valid;
            r_head    <= n_head;
        end
    end

    irr_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (w_rx),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // ram read data holds while the first stage is stalled, since no new read issues
    assign w_p_data = (r_p_res.is_read && r_p_res.entry_valid) ? w_rd_data : 8'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_p_valid <= w_res_valid;
            end
            if (w_p_adv) begin
                r_o_valid <= r_p_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && w_res_valid) begin
            r_p_res <= w_res;
        end
        if (w_p_adv && r_p_valid) begin
            r_o_status <= r_p_res.status;
            r_o_count  <= r_p_res.count;
            r_o_data   <= w_p_data;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {r_o_data, r_o_count};
    assign o_m_axis_tuser  = r_o_status;

endmodule

/* dv/tb_isp_reply_receiver.sv */
`timescale 1ns / 1ps

module tb_isp_reply_receiver;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        irr_pkg::t_opcode op;
        logic [7:0]       rx;
        logic [15:0]      tlim;
        logic [6:0]       idx;
    } t_request;

    typedef struct {
        irr_pkg::t_status status;
        logic [7:0]       count;
        logic [7:0]       data;
    } t_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [7:0]  i_cfg_wr_data = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata = '0;  // rx_byte[7:0], timeout_limit[23:8], read_index[30:24]
    logic [1:0]  i_s_axis_tuser = '0;  // opcode
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [15:0] o_m_axis_tdata;       // received_count[7:0], data_byte[15:8]
    logic [1:0]  o_m_axis_tuser;       // status

    isp_reply_receiver i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    // receiver state as the block should hold it
    logic [7:0]  rx_store [irr_pkg::STORE_DEPTH];
    int          held_cnt = 0;
    logic [15:0] ms_total = '0;
    logic [7:0]  ms_quiet = '0;
    bit          armed = 1'b0;
    logic [15:0] tmo_ms = '0;
    logic [7:0]  quiet_limit = irr_pkg::IDLE_LIMIT_RESET;

    t_request req_backlog [$];
    t_reply   due_replies [$];
    t_request cur_req;
    int       live_reqs = 0;
    int       errors = 0;
    int       cycle_cnt = 0;
    int       send_gap = 0;
    int       recv_gap = 0;
    bit       idle_on = 1'b0;

    function automatic bit head_status(output irr_pkg::t_status st);
        st = irr_pkg::ST_OK;
        if (held_cnt < 2) return 1'b0;
        if (rx_store[0] == irr_pkg::CH_O && rx_store[1] == irr_pkg::CH_K) return 1'b1;
        st = irr_pkg::ST_FAIL;
        if (rx_store[0] == irr_pkg::CH_F && rx_store[1] == irr_pkg::CH_L) return 1'b1;
        return 1'b0;
    endfunction

    task automatic add_reply(input irr_pkg::t_status st, input logic [7:0] data);
        t_reply r;
        r.status = st;
        r.count = 8'(held_cnt);
        r.data = data;
        due_replies.push_back(r);
    endtask

    task automatic track_request(input t_request r);
        irr_pkg::t_status st;
        int plen;
        live_reqs++;
        case (r.op)
            irr_pkg::OP_START: begin
                foreach (rx_store[k]) rx_store[k] = '0;
                held_cnt = 0;
                ms_total = '0;
                ms_quiet = '0;
                tmo_ms = r.tlim;
                armed = (r.tlim != 16'd0);
                if (!armed) add_reply(irr_pkg::ST_TIMEOUT, 8'h00);
            end
            irr_pkg::OP_READ: begin
                add_reply(irr_pkg::ST_READ, rx_store[r.idx]);
            end
            irr_pkg::OP_BYTE: if (armed) begin
                ms_quiet = '0;
                if (held_cnt < irr_pkg::STORE_DEPTH) begin
                    rx_store[held_cnt] = r.rx;
                    held_cnt++;
                end
                // pending marker: drop what was held and start the wait over
                if (held_cnt >= 2 && rx_store[0] == irr_pkg::CH_P
                        && rx_store[1] == irr_pkg::CH_D) begin
                    held_cnt = 0;
                    ms_total = '0;
                end else if (head_status(st) && held_cnt >= irr_pkg::HEAD_LEN) begin
                    plen = int'({rx_store[3], rx_store[2]});
                    if (plen > int'(irr_pkg::PLEN_MAX)) plen = int'(irr_pkg::PLEN_MAX);
                    if (held_cnt >= irr_pkg::HEAD_LEN + plen) begin
                        armed = 1'b0;
                        add_reply(st, 8'h00);
                    end
                end
            end
            irr_pkg::OP_TICK: if (armed) begin
                if (ms_total != 16'hFFFF) ms_total++;
                if (ms_quiet != 8'hFF) ms_quiet++;
                // idle completion takes priority over the overall timeout
                if (head_status(st) && ms_quiet >= quiet_limit) begin
                    armed = 1'b0;
                    add_reply(st, 8'h00);
                end else if (ms_total >= tmo_ms) begin
                    armed = 1'b0;
                    add_reply(irr_pkg::ST_TIMEOUT, 8'h00);
                end
            end
        endcase
    endtask

    task automatic push_req(input irr_pkg::t_opcode op, input logic [7:0] rx,
                            input logic [15:0] tlim, input logic [6:0] idx);
        t_request r;
        r.op = op;
        r.rx = rx;
        r.tlim = tlim;
        r.idx = idx;
        req_backlog.push_back(r);
    endtask

    task automatic push_byte(input logic [7:0] b);
        push_req(irr_pkg::OP_BYTE, b, 16'($urandom), 7'($urandom));
    endtask

    task automatic push_tick();
        push_req(irr_pkg::OP_TICK, 8'($urandom), 16'($urandom), 7'($urandom));
    endtask

    task automatic push_read(input logic [6:0] idx);
        push_req(irr_pkg::OP_READ, 8'($urandom), 16'($urandom), idx);
    endtask

    task automatic push_start(input logic [15:0] tlim);
        push_req(irr_pkg::OP_START, 8'($urandom), tlim, 7'($urandom));
    endtask

    // one exchange: start, a reply byte stream with ticks and reads mixed in, then ticks and reads
    task automatic queue_exchange();
        logic [7:0]  body [$];
        logic [15:0] tl;
        logic [15:0] plen_f;
        int shape;
        int hd_len;
        int plen_eff;
        int cut;
        int n_tail;
        case ($urandom_range(0, 9))
            0:       tl = 16'd0;
            1:       tl = 16'hFFFF;
            2, 3:    tl = 16'($urandom);
            default: tl = 16'($urandom_range(1, 40));
        endcase
        push_start(tl);
        shape = $urandom_range(0, 19);
        if (shape < 3) begin
            repeat ($urandom_range(0, 6)) body.push_back(8'($urandom));
            if (body.size() > 0) begin
                case ($urandom_range(0, 3))
                    0: body[0] = irr_pkg::CH_O;
                    1: body[0] = irr_pkg::CH_F;
                    2: body[0] = irr_pkg::CH_P;
                    default: ;
                endcase
            end
        end else if (shape == 3) begin
            // no valid head, so the store fills up and stays full unless the exchange times out first
            repeat ($urandom_range(129, 134)) body.push_back(8'($urandom));
            body[0] = irr_pkg::CH_D;
        end else begin
            if (shape < 7) begin
                body.push_back(irr_pkg::CH_P);
                body.push_back(irr_pkg::CH_D);
            end
            if ($urandom_range(0, 1) == 0) begin
                body.push_back(irr_pkg::CH_O);
                body.push_back(irr_pkg::CH_K);
            end else begin
                body.push_back(irr_pkg::CH_F);
                body.push_back(irr_pkg::CH_L);
            end
            case ($urandom_range(0, 19))
                0:       plen_f = 16'hFFFF;
                1:       plen_f = 16'($urandom);
                2:       plen_f = 16'($urandom_range(100, 130));
                default: plen_f = 16'($urandom_range(0, 8));
            endcase
            body.push_back(plen_f[7:0]);
            body.push_back(plen_f[15:8]);
            hd_len = body.size();
            plen_eff = (plen_f > irr_pkg::PLEN_MAX) ? int'(irr_pkg::PLEN_MAX) : int'(plen_f);
            repeat (plen_eff) body.push_back(8'($urandom));
            // cut short so the reply has to finish on silence
            if ($urandom_range(0, 3) == 0) begin
                cut = $urandom_range(hd_len - 2, body.size() - 1);
                while (body.size() > cut) void'(body.pop_back());
            end
        end
        foreach (body[k]) begin
            if ($urandom_range(0, 7) == 0) push_tick();
            if ($urandom_range(0, 11) == 0) push_read(7'($urandom));
            push_byte(body[k]);
        end
        n_tail = ($urandom_range(0, 3) == 0) ? int'(quiet_limit) + 2 : $urandom_range(0, 10);
        repeat (n_tail) push_tick();
        repeat ($urandom_range(0, 2)) push_read(7'($urandom));
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (req_backlog.size() != 0 || i_s_axis_tvalid || due_replies.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random(input int target);
        while (live_reqs < target) begin
            if (req_backlog.size() < 8) queue_exchange();
            @(posedge i_clk);
        end
        drain();
    endtask

    task automatic write_idle_limit(input logic [7:0] v);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        quiet_limit = v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic check_reply();
        t_reply want;
        if (due_replies.size() == 0) begin
            $error("unexpected result: status %0d count %0d data %0h",
                   o_m_axis_tuser, o_m_axis_tdata[7:0], o_m_axis_tdata[15:8]);
            errors++;
            return;
        end
        want = due_replies.pop_front();
        if (o_m_axis_tuser !== want.status) begin
            $error("status: expected %0d actual %0d", want.status, o_m_axis_tuser);
            errors++;
        end
        if (o_m_axis_tdata[7:0] !== want.count) begin
            $error("received_count: expected %0d actual %0d", want.count, o_m_axis_tdata[7:0]);
            errors++;
        end
        if (o_m_axis_tdata[15:8] !== want.data) begin
            $error("data_byte: expected %0h actual %0h", want.data, o_m_axis_tdata[15:8]);
            errors++;
        end
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) track_request(cur_req);
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_s_axis_tvalid <= 1'b0;
                end else if (idle_on && $urandom_range(0, 9) == 0) begin
                    send_gap <= $urandom_range(0, 2);
                    i_s_axis_tvalid <= 1'b0;
                end else if (req_backlog.size() > 0) begin
                    cur_req = req_backlog.pop_front();
                    i_s_axis_tdata <= {1'b0, cur_req.idx, cur_req.tlim, cur_req.rx};
                    i_s_axis_tuser <= cur_req.op;
                    i_s_axis_tvalid <= 1'b1;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) check_reply();
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_m_axis_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                recv_gap <= $urandom_range(0, 2);
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        foreach (rx_store[k]) rx_store[k] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reads after reset, ignored items, zero timeout, pending then ok, then a fail reply
        push_read(7'd0);
        push_read(7'd127);
        push_byte(8'hFF);
        push_tick();
        push_start(16'd0);
        push_start(16'd1);
        push_tick();
        push_start(16'hFFFF);
        push_start(16'hFFFF);
        push_byte(irr_pkg::CH_P);
        push_byte(irr_pkg::CH_D);
        push_byte(irr_pkg::CH_O);
        push_byte(irr_pkg::CH_K);
        push_byte(8'h02);
        push_byte(8'h00);
        push_byte(8'hAA);
        push_byte(8'h55);
        push_read(7'd5);
        push_start(16'hFFFF);
        push_byte(irr_pkg::CH_F);
        push_byte(irr_pkg::CH_L);
        push_byte(8'h00);
        push_byte(8'h00);
        drain();

        idle_on = 1'b1;
        write_idle_limit(8'd0);
        run_random(250);

        // idle and timeout falling on the same tick
        write_idle_limit(8'd1);
        push_start(16'd1);
        push_byte(irr_pkg::CH_O);
        push_byte(irr_pkg::CH_K);
        push_tick();
        run_random(500);

        write_idle_limit(8'd255);
        run_random(750);

        write_idle_limit(8'($urandom_range(2, 40)));
        run_random(900);
        run_random(1050);

        idle_on = 1'b0;
        write_idle_limit(irr_pkg::IDLE_LIMIT_RESET);
        run_random(1350);

        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
